// File: rtl/lip_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Lagrange interpolation core.
// No dependencies; imported by lip_front, lip_back and the top level.
package lip_pkg;

    localparam int IDX_W  = 3;   // node slot field width
    localparam int DATA_W = 32;  // Q16.16 word
    localparam int CNT_W  = 4;   // node_count register width

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Command that the front hands to the back through the queue.
    // val_a: node x for a load, query x for an evaluate. val_b: node y.
    typedef struct packed {
        logic              is_eval;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] val_a;
        logic [DATA_W-1:0] val_b;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              overflow;
        logic              degenerate;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DG_CHECK,
        S_DG_RD,
        S_DG_CMP,
        S_TERM,
        S_K_CHECK,
        S_RD,
        S_DIV_SET,
        S_DIV,
        S_MUL_SET,
        S_MUL,
        S_MUL_FIN,
        S_Y_SET,
        S_ACC,
        S_FINAL,
        S_DONE
    } t_state;

endpackage

// File: rtl/lip_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lip_queue.sv
`timescale 1ns / 1ps
// Small synchronous FIFO that decouples the front from the back.
// No dependencies.
module lip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/lip_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, classifies them and packs queue commands.
// Depends on lip_pkg.
module lip_front #(
    parameter int MAX_NODES = 8
) (
    input  logic                        i_push,
    input  logic                        i_opcode,
    input  logic [lip_pkg::IDX_W-1:0]   i_node_index,
    input  logic [lip_pkg::DATA_W-1:0]  i_node_x,
    input  logic [lip_pkg::DATA_W-1:0]  i_node_y,
    input  logic [lip_pkg::DATA_W-1:0]  i_query_x,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output lip_pkg::t_cmd               o_cmd
);
    import lip_pkg::*;

    logic slot_ok;

    // loads to slots past the table are taken and dropped
    assign slot_ok  = (32'(i_node_index) < MAX_NODES);
    assign o_q_push = i_push && !i_q_full && (i_opcode || slot_ok);

    always_comb begin
        o_cmd.is_eval = i_opcode;
        o_cmd.slot    = i_node_index;
        o_cmd.val_a   = i_opcode ? i_query_x : i_node_x;
        o_cmd.val_b   = i_node_y;
    end

endmodule

// File: rtl/lip_back.sv
`timescale 1ns / 1ps
// Back end: node tables, shared bit-serial divider and 32x32 multiplier,
// evaluation sequencer and result register. Depends on lip_pkg, lip_ram.
module lip_back #(
    parameter int MAX_NODES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  lip_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    input  logic [lip_pkg::CNT_W-1:0]  i_node_count,
    output logic                       o_res_valid,
    output lip_pkg::t_result           o_res,
    input  logic                       i_res_pop
);
    import lip_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 2);
    localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_LO = -SUM_HI;

    t_state r_state, n_state;

    logic [CW-1:0]  r_n, r_i, r_k;
    logic [31:0]    r_query;
    logic           r_ovf, r_pn, r_yneg, r_ymul;
    logic [63:0]    r_pm, r_m, r_sum;
    // divider
    logic [32:0]    r_den;
    logic [33:0]    r_rem;
    logic [64:0]    r_dvd, r_quo;
    logic [6:0]     r_dcnt;
    // multiplier
    logic [63:0]    r_ma, r_mb;
    logic [63:0]    r_prod;
    logic [1:0]     r_psh;
    logic [2:0]     r_mcnt;
    logic [127:0]   r_acc;
    // results
    t_result        r_res, r_out;
    logic           r_out_valid;

    logic           ram_we, res_load;
    logic [31:0]    xa_rdata, xb_rdata, y_rdata;

    // combinational helpers
    logic [CW-1:0]  n_sel;
    logic signed [32:0] num_s, den_s;
    logic [33:0]    rem_sh;
    logic           ge;
    logic [31:0]    a_half, b_half;
    logic [127:0]   prod_sh;
    logic           mul_sat;
    logic [63:0]    mul_val;
    logic signed [64:0] sum_nx;
    logic [63:0]    sum_mag;
    logic [47:0]    q_mag;

    lip_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xa (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(i_cmd.slot)),
        .i_wdata(i_cmd.val_a), .i_raddr(r_i[AW-1:0]), .o_rdata(xa_rdata)
    );
    lip_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xb (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(i_cmd.slot)),
        .i_wdata(i_cmd.val_a), .i_raddr(r_k[AW-1:0]), .o_rdata(xb_rdata)
    );
    lip_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_y (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(i_cmd.slot)),
        .i_wdata(i_cmd.val_b), .i_raddr(r_i[AW-1:0]), .o_rdata(y_rdata)
    );

    assign n_sel = (32'(i_node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(i_node_count);
    assign num_s = {r_query[31], r_query} - {xb_rdata[31], xb_rdata};
    assign den_s = {xa_rdata[31], xa_rdata} - {xb_rdata[31], xb_rdata};
    assign rem_sh = {r_rem[32:0], r_dvd[64]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign a_half = r_mcnt[0] ? r_ma[63:32] : r_ma[31:0];
    assign b_half = r_mcnt[1] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        case (r_psh)
            2'd0:    prod_sh = {64'b0, r_prod};
            2'd1:    prod_sh = {32'b0, r_prod, 32'b0};
            default: prod_sh = {r_prod, 64'b0};
        endcase
    end

    always_comb begin
        if (r_ymul) begin
            mul_sat = (r_acc[127:79] != '0);
            mul_val = r_acc[79:16];
        end else begin
            mul_sat = (r_acc[127:95] != '0);
            mul_val = r_acc[95:32];
        end
    end

    assign sum_nx  = (r_pn ^ r_yneg) ? $signed({r_sum[63], r_sum}) - $signed({1'b0, r_m})
                                     : $signed({r_sum[63], r_sum}) + $signed({1'b0, r_m});
    assign sum_mag = r_sum[63] ? (64'd0 - r_sum) : r_sum;
    assign q_mag   = sum_mag[63:16];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_cmd_valid && i_cmd.is_eval) n_state = S_DG_CHECK;
            S_DG_CHECK: n_state = (r_k >= r_n) ? S_TERM : S_DG_RD;
            S_DG_RD:    n_state = S_DG_CMP;
            S_DG_CMP:   n_state = (xa_rdata == xb_rdata) ? S_DONE : S_DG_CHECK;
            S_TERM:     n_state = (r_i == r_n) ? S_FINAL : S_K_CHECK;
            S_K_CHECK: begin
                if (r_k == r_n) n_state = S_Y_SET;
                else if (r_k != r_i) n_state = S_RD;
            end
            S_RD:       n_state = S_DIV_SET;
            S_DIV_SET:  n_state = S_DIV;
            S_DIV:      if (r_dcnt == '0) n_state = S_MUL_SET;
            S_MUL_SET:  n_state = S_MUL;
            S_MUL:      if (r_mcnt == 3'd4) n_state = S_MUL_FIN;
            S_MUL_FIN:  n_state = r_ymul ? S_ACC : S_K_CHECK;
            S_Y_SET:    n_state = S_MUL;
            S_ACC:      n_state = S_TERM;
            S_FINAL:    n_state = S_DONE;
            S_DONE:     if (!r_out_valid || i_res_pop) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        ram_we    = o_cmd_pop && !i_cmd.is_eval;
        res_load  = (r_state == S_DONE) && (!r_out_valid || i_res_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= r_res;
        end
        if (r_state == S_MUL && r_mcnt != 3'd4) begin
            r_prod <= {32'b0, a_half} * {32'b0, b_half};
            r_psh  <= 2'(r_mcnt[0]) + 2'(r_mcnt[1]);
        end
        case (r_state)
            S_IDLE: begin
                r_query <= i_cmd.val_a;
                r_n     <= n_sel;
                r_ovf   <= 1'b0;
                r_sum   <= '0;
                r_i     <= '0;
                r_k     <= CW'(1);
            end
            S_DG_CHECK: begin
                if (r_k >= r_n) r_i <= '0;
            end
            S_DG_CMP: begin
                if (xa_rdata == xb_rdata) begin
                    r_res.value      <= '0;
                    r_res.overflow   <= 1'b0;
                    r_res.degenerate <= 1'b1;
                end else if (r_k + 1'b1 < r_n) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                    r_k <= r_i + CW'(2);
                end
            end
            S_TERM: begin
                r_pm <= 64'h1_0000_0000;
                r_pn <= 1'b0;
                r_k  <= '0;
            end
            S_K_CHECK: begin
                if (r_k != r_n && r_k == r_i) r_k <= r_k + 1'b1;
            end
            S_DIV_SET: begin
                r_den  <= den_s[32] ? 33'(-den_s) : 33'(den_s);
                r_dvd  <= {(num_s[32] ? 33'(-num_s) : 33'(num_s)), 32'b0};
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= 7'd64;
                r_pn   <= r_pn ^ (num_s[32] ^ den_s[32]);
            end
            S_DIV: begin
                r_rem  <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_quo  <= {r_quo[63:0], ge};
                r_dvd  <= {r_dvd[63:0], 1'b0};
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_MUL_SET: begin
                r_ma   <= r_pm;
                if (r_quo[64:63] != 2'b00) begin
                    r_mb  <= MAG_MAX;
                    r_ovf <= 1'b1;
                end else begin
                    r_mb  <= r_quo[63:0];
                end
                r_ymul <= 1'b0;
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            S_Y_SET: begin
                r_ma   <= {32'b0, (y_rdata[31] ? 32'd0 - y_rdata : y_rdata)};
                r_mb   <= r_pm;
                r_yneg <= y_rdata[31];
                r_ymul <= 1'b1;
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            S_MUL: begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt != '0) r_acc <= r_acc + prod_sh;
            end
            S_MUL_FIN: begin
                if (mul_sat) r_ovf <= 1'b1;
                if (r_ymul) begin
                    r_m <= mul_sat ? MAG_MAX : mul_val;
                end else begin
                    r_pm <= mul_sat ? MAG_MAX : mul_val;
                    r_k  <= r_k + 1'b1;
                end
            end
            S_ACC: begin
                if (sum_nx > SUM_HI) begin
                    r_sum <= MAG_MAX;
                    r_ovf <= 1'b1;
                end else if (sum_nx < SUM_LO) begin
                    r_sum <= 64'd0 - MAG_MAX;
                    r_ovf <= 1'b1;
                end else begin
                    r_sum <= sum_nx[63:0];
                end
                r_i <= r_i + 1'b1;
            end
            S_FINAL: begin
                r_res.degenerate <= 1'b0;
                if (!r_sum[63] && q_mag > 48'h7FFF_FFFF) begin
                    r_res.value    <= 32'h7FFF_FFFF;
                    r_res.overflow <= 1'b1;
                end else if (r_sum[63] && q_mag > 48'h8000_0000) begin
                    r_res.value    <= 32'h8000_0000;
                    r_res.overflow <= 1'b1;
                end else begin
                    r_res.value    <= r_sum[63] ? 32'd0 - q_mag[31:0] : q_mag[31:0];
                    r_res.overflow <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: rtl/lagrange_interpolation_core.sv
`timescale 1ns / 1ps
// Lagrange interpolation core, top level: front, command queue, back end.
// Depends on lip_pkg, lip_front, lip_queue, lip_back, lip_ram.
//
// Items enter on a queue-style port (push/full) and results leave on one
// (empty/pop). A load item (opcode 0) stores node (x, y) in a slot and gives
// no result; an evaluate item (opcode 1) returns the Lagrange polynomial
// through the first node_count nodes (capped at MAX_NODES) at query_x, all
// signed Q16.16, saturated, with overflow and degenerate flags. Items pass
// through a two-entry command queue, so loads and evaluates finish in order
// and the port keeps taking items while the back end is busy until the queue
// is full. A load is written to the node tables when the back end pops it. An
// evaluate first checks the P = n*(n-1)/2 abscissa pairs, then runs each
// factor through the bit-serial divider and the shared 32x32 multiplier
// (four partial products per 64x64 multiply). Node tables are
// not cleared at reset; evaluate only over loaded slots. node_count is to
// be written while the core is idle.
module lagrange_interpolation_core #(
    parameter int MAX_NODES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lip_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_opcode,
    input  logic [lip_pkg::IDX_W-1:0]   i_node_index,
    input  logic [lip_pkg::DATA_W-1:0]  i_node_x,
    input  logic [lip_pkg::DATA_W-1:0]  i_node_y,
    input  logic [lip_pkg::DATA_W-1:0]  i_query_x,
    output logic                        empty,
    input  logic                        pop,
    output logic [lip_pkg::DATA_W-1:0]  o_interpolated_value,
    output logic                        o_overflow,
    output logic                        o_degenerate
);
    import lip_pkg::*;

    logic [CNT_W-1:0] r_node_count;
    logic             q_full, q_empty, q_push, q_pop;
    t_cmd             f_cmd, b_cmd;
    logic [$bits(t_cmd)-1:0] q_rdata;
    t_result          res;
    logic             res_valid;

    // node_count register, reset to two nodes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(2);
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    lip_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_push(push), .i_opcode(i_opcode), .i_node_index(i_node_index),
        .i_node_x(i_node_x), .i_node_y(i_node_y), .i_query_x(i_query_x),
        .i_q_full(q_full), .o_q_push(q_push), .o_cmd(f_cmd)
    );

    lip_queue #(.WIDTH($bits(t_cmd)), .DEPTH(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(f_cmd), .o_full(q_full),
        .i_pop(q_pop), .o_data(q_rdata), .o_empty(q_empty)
    );

    assign b_cmd = t_cmd'(q_rdata);

    lip_back #(.MAX_NODES(MAX_NODES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(!q_empty), .i_cmd(b_cmd), .o_cmd_pop(q_pop),
        .i_node_count(r_node_count),
        .o_res_valid(res_valid), .o_res(res), .i_res_pop(pop)
    );

    assign full                 = q_full;
    assign empty                = !res_valid;
    assign o_interpolated_value = res.value;
    assign o_overflow           = res.overflow;
    assign o_degenerate         = res.degenerate;

endmodule

// File: bench/tb_lagrange_interpolation_core.sv
`timescale 1ns / 1ps
// Testbench of lagrange_interpolation_core: queue-style driver and monitor,
// with an own fixed-point model of the interpolation. Depends on lip_pkg.
module tb_lagrange_interpolation_core;
    import lip_pkg::*;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;
    localparam int   NODES = 8;
    localparam int   SETTLE_CYCLES = 24;      // queue plus one load, with margin
    localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

    typedef struct {
        logic        op;
        logic [2:0]  slot;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] qx;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_en = 1'b0;
    logic [3:0]  cfg_data = '0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty;
    logic        op_d = OP_LOAD;
    logic [2:0]  slot_d = '0;
    logic [31:0] nx_d = '0, ny_d = '0, qx_d = '0;
    logic [31:0] value_o;
    logic        ovf_o, degen_o;

    t_item   pending_items[$];
    t_result expected_results[$];
    logic [31:0] x_nodes[NODES];
    logic [31:0] y_nodes[NODES];
    logic [3:0]  node_cnt = 4'd2;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      errors = 0;

    lagrange_interpolation_core #(.MAX_NODES(NODES)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_en), .i_cfg_wr_data(cfg_data),
        .push(push), .full(full),
        .i_opcode(op_d), .i_node_index(slot_d),
        .i_node_x(nx_d), .i_node_y(ny_d), .i_query_x(qx_d),
        .empty(empty), .pop(pop),
        .o_interpolated_value(value_o), .o_overflow(ovf_o), .o_degenerate(degen_o)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- fixed-point model ----------------
    function automatic logic [63:0] magnitude(longint signed v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // (a*b) >> sh on magnitudes, truncated, saturates to MAG_MAX
    function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh,
                                              inout bit ovf);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        if ((p >> (63 + sh)) != 0) begin
            ovf = 1'b1;
            return MAG_MAX;
        end
        return 64'(p >> sh);
    endfunction

    // (a << 32) / b on magnitudes, b nonzero
    function automatic logic [63:0] div_q32(logic [63:0] a, logic [63:0] b, inout bit ovf);
        logic [95:0] q;
        if (((a / b) >> 31) != 0) begin
            ovf = 1'b1;
            return MAG_MAX;
        end
        q = {a, 32'b0} / {32'b0, b};
        return q[63:0];
    endfunction

    function automatic longint signed sat_add(longint signed s, longint signed t,
                                              inout bit ovf);
        longint signed lim;
        lim = longint'(MAG_MAX);
        if (t > 0 && s > lim - t) begin
            ovf = 1'b1;
            return lim;
        end
        if (t < 0 && s < -lim - t) begin
            ovf = 1'b1;
            return -lim;
        end
        return s + t;
    endfunction

    function automatic t_result lagrange_eval(logic [31:0] qx);
        t_result r;
        int n;
        longint signed x, xi, yi, num, den, sum, term;
        logic [63:0] pm, f, m, q;
        bit ovf, pn, neg;
        r = '0;
        n = node_cnt > NODES ? NODES : node_cnt;
        for (int i = 0; i < n; i++)
            for (int k = i + 1; k < n; k++)
                if (x_nodes[i] == x_nodes[k]) begin
                    r.degenerate = 1'b1;
                    return r;
                end
        x = longint'($signed(qx));
        sum = 0;
        ovf = 1'b0;
        for (int i = 0; i < n; i++) begin
            xi = longint'($signed(x_nodes[i]));
            yi = longint'($signed(y_nodes[i]));
            pm = Q32_ONE;
            pn = 1'b0;
            for (int k = 0; k < n; k++) begin
                if (k != i) begin
                    num = x - longint'($signed(x_nodes[k]));
                    den = xi - longint'($signed(x_nodes[k]));
                    f = div_q32(magnitude(num), magnitude(den), ovf);
                    pm = mul_trunc(pm, f, 32, ovf);
                    pn = pn ^ ((num < 0) != (den < 0));
                end
            end
            m = mul_trunc(magnitude(yi), pm, 16, ovf);
            term = (pn != (yi < 0)) ? -longint'(m) : longint'(m);
            sum = sat_add(sum, term, ovf);
        end
        neg = sum < 0;
        q = magnitude(sum) >> 16;
        if (!neg && q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            ovf = 1'b1;
        end else if (neg && q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            ovf = 1'b1;
        end
        r.value = neg ? 32'(-q) : q[31:0];
        r.overflow = ovf;
        return r;
    endfunction

    // model update for one accepted item
    task automatic accept_item(t_item it);
        if (it.op == OP_LOAD) begin
            x_nodes[it.slot] = it.nx;
            y_nodes[it.slot] = it.ny;
        end else begin
            expected_results.push_back(lagrange_eval(it.qx));
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_item it;
        bit    take;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (push)
                accept_item('{op_d, slot_d, nx_d, ny_d, qx_d});
            take = pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (take) begin
                it = pending_items.pop_front();
                op_d   <= it.op;
                slot_d <= it.slot;
                nx_d   <= it.nx;
                ny_d   <= it.ny;
                qx_d   <= it.qx;
            end
            push <= take;
        end
    end

    // ---------------- monitor ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", value_o, 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (value_o !== want.value)
                        report_mismatch("value", value_o, want.value);
                    if (ovf_o !== want.overflow)
                        report_mismatch("overflow", ovf_o, want.overflow);
                    if (degen_o !== want.degenerate)
                        report_mismatch("degenerate", degen_o, want.degenerate);
                end
            end
            pop <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_load(int slot, logic [31:0] x, logic [31:0] y);
        pending_items.push_back('{OP_LOAD, 3'(slot), x, y, $urandom});
    endtask

    task automatic add_eval(logic [31:0] q);
        pending_items.push_back('{OP_EVAL, 3'($urandom), $urandom, $urandom, q});
    endtask

    // wait until every item is in and every result is out, then let loads settle
    task automatic drain();
        while (pending_items.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [3:0] v);
        @(posedge i_clk);
        cfg_en   <= 1'b1;
        cfg_data <= v;
        node_cnt = v;
        @(posedge i_clk);
        cfg_en <= 1'b0;
    endtask

    // mostly whole node sets followed by evaluates; the rest raw noise
    task automatic random_phase(int target);
        int ne, added, step, off, evals;
        logic [31:0] y;
        ne = node_cnt > NODES ? NODES : node_cnt;
        added = 0;
        while (added < target) begin
            if ($urandom_range(0, 9) < 7) begin
                step = $urandom_range(1, 32'h0004_0000);
                off = int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                if ($urandom_range(0, 1)) step = -step;
                for (int k = 0; k < ne; k++) begin
                    y = ($urandom_range(0, 7) == 0) ? $urandom
                        : 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
                    add_load(k, 32'(off + k * step), y);
                end
                evals = ne >= 5 ? 1 : $urandom_range(1, 4);
                for (int e = 0; e < evals; e++)
                    add_eval(32'(off - step / 2 + int'($urandom_range(0, (ne + 1) *
                             (step < 0 ? -step : step))) * (step < 0 ? -1 : 1)));
                added += ne + evals;
            end else if ($urandom_range(0, 1) || (ne > 4 && $urandom_range(0, 3) != 0)) begin
                add_load($urandom_range(0, NODES - 1), $urandom, $urandom);
                added++;
            end else begin
                add_eval($urandom);
                added++;
            end
        end
    endtask

    initial begin
        int counts[16] = '{2, 3, 4, 2, 8, 0, 1, 15, 3, 2, 5, 4, 6, 2, 7, 3};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill every slot first so no unwritten node is ever read
        write_count(4'd2);
        for (int k = 0; k < NODES; k++)
            add_load(k, 32'(k) << 16, 32'(k * 3 - 5) << 16);
        add_eval(32'h0000_8000);                   // between two nodes
        add_eval(32'h0001_0000);                   // on a node
        add_eval(32'h7FFF_FFFF);                   // query extremes
        add_eval(32'h8000_0000);
        add_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // field extremes, overflow
        add_load(1, 32'h8000_0000, 32'h8000_0000);
        add_eval(32'h0000_0000);
        add_eval(32'h7FFF_FFFF);
        add_load(1, 32'h7FFF_FFFF, 32'h0001_0000); // equal abscissas
        add_eval(32'h0000_0000);
        add_load(0, 32'h0000_0000, 32'h0002_0000);
        add_load(1, 32'h0001_0000, 32'hFFFF_0000);
        add_eval(32'h0000_4000);
        drain();

        for (int p = 0; p < 16; p++) begin
            send_idle_pct = p < 6 ? 20 : (p < 11 ? 75 : 0);
            recv_idle_pct = p < 6 ? 75 : (p < 11 ? 20 : 0);
            write_count(4'(counts[p]));
            random_phase(122);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
